// File: rtl/chp_pkg.sv
// ----------------------------------------------------------------------------
// chp_pkg
// Shared types, constants and helpers for the container header parser.
// ----------------------------------------------------------------------------
package chp_pkg;

	// header layout
	localparam int unsigned COUNT_W = 5;
	localparam logic [COUNT_W-1:0] HDR_LEN = 5'd16;
	localparam logic [7:0] VERSION_VALUE = 8'h01;
	localparam logic [7:0] MAX_MODE_RESET = 8'd4;

	// magic bytes, in order of arrival
	localparam logic [7:0] MAGIC_0 = 8'h44;
	localparam logic [7:0] MAGIC_1 = 8'h54;
	localparam logic [7:0] MAGIC_2 = 8'h4D;
	localparam logic [7:0] MAGIC_3 = 8'h31;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SHORT     = 2'd1,
		ST_BAD_MAGIC = 2'd2,
		ST_BAD_HDR   = 2'd3
	} status_t;

	// one parsed result
	typedef struct packed {
		logic [31:0] pay_crc;
		logic [31:0] pay_len;
		logic [7:0]  param;
		logic [7:0]  flags;
		logic [7:0]  mode;
		status_t     status;
	} result_t;

	// expected magic byte for header positions zero to three
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = MAGIC_0;
			2'd1: b = MAGIC_1;
			2'd2: b = MAGIC_2;
			2'd3: b = MAGIC_3;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/chp_hdr_track.sv
// ----------------------------------------------------------------------------
// chp_hdr_track
// Input register, header field capture and checks, one result per buffer.
// ----------------------------------------------------------------------------
module chp_hdr_track (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                res_room,
	output logic                res_valid,
	output chp_pkg::result_t    res
);

	logic [7:0] max_mode_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;

	logic [chp_pkg::COUNT_W-1:0] count_q, count_n;
	logic        magic_bad_q, magic_bad_n;
	logic        hdr_bad_q, hdr_bad_n;
	logic [7:0]  mode_q, mode_n;
	logic [7:0]  flags_q, flags_n;
	logic [7:0]  param_q, param_n;
	logic [31:0] len_q, len_n;
	logic [31:0] crc_q, crc_n;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mode_q <= chp_pkg::MAX_MODE_RESET;
		end else if (cfg_wr_en) begin
			max_mode_q <= cfg_wr_data;
		end
	end

	// stage advances unless a final byte meets a full result buffer
	assign adv      = valid_s1 && (!last_s1 || res_room);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// header state after taking the registered byte
	always_comb begin
		count_n     = count_q;
		magic_bad_n = magic_bad_q;
		hdr_bad_n   = hdr_bad_q;
		mode_n      = mode_q;
		flags_n     = flags_q;
		param_n     = param_q;
		len_n       = len_q;
		crc_n       = crc_q;
		if (count_q < chp_pkg::HDR_LEN) begin
			count_n = count_q + 5'd1;
			unique case (count_q[3:0])
				4'd0, 4'd1, 4'd2, 4'd3: begin
					if (byte_s1 != chp_pkg::magic_byte(count_q[1:0]))
						magic_bad_n = 1'b1;
				end
				4'd4: begin
					if (byte_s1 != chp_pkg::VERSION_VALUE)
						hdr_bad_n = 1'b1;
				end
				4'd5: begin
					mode_n = byte_s1;
					if (byte_s1 > max_mode_q)
						hdr_bad_n = 1'b1;
				end
				4'd6: flags_n = byte_s1;
				4'd7: param_n = byte_s1;
				4'd8, 4'd9, 4'd10, 4'd11: begin
					len_n[{count_q[1:0], 3'b000} +: 8] = byte_s1;
				end
				4'd12, 4'd13, 4'd14, 4'd15: begin
					crc_n[{count_q[1:0], 3'b000} +: 8] = byte_s1;
				end
			endcase
		end
	end

	// result for the final byte, short buffer first
	always_comb begin
		res = '0;
		priority if (count_n < chp_pkg::HDR_LEN) begin
			res.status = chp_pkg::ST_SHORT;
		end else if (magic_bad_n) begin
			res.status = chp_pkg::ST_BAD_MAGIC;
		end else if (hdr_bad_n) begin
			res.status = chp_pkg::ST_BAD_HDR;
		end else begin
			res.status  = chp_pkg::ST_OK;
			res.mode    = mode_n;
			res.flags   = flags_n;
			res.param   = param_n;
			res.pay_len = len_n;
			res.pay_crc = crc_n;
		end
	end

	assign res_valid = adv && last_s1;

	// header state, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			magic_bad_q <= 1'b0;
			hdr_bad_q   <= 1'b0;
			mode_q      <= '0;
			flags_q     <= '0;
			param_q     <= '0;
			len_q       <= '0;
			crc_q       <= '0;
		end else if (adv) begin
			if (last_s1) begin
				count_q     <= '0;
				magic_bad_q <= 1'b0;
				hdr_bad_q   <= 1'b0;
				mode_q      <= '0;
				flags_q     <= '0;
				param_q     <= '0;
				len_q       <= '0;
				crc_q       <= '0;
			end else begin
				count_q     <= count_n;
				magic_bad_q <= magic_bad_n;
				hdr_bad_q   <= hdr_bad_n;
				mode_q      <= mode_n;
				flags_q     <= flags_n;
				param_q     <= param_n;
				len_q       <= len_n;
				crc_q       <= crc_n;
			end
		end
	end

endmodule

// File: rtl/chp_out_buf.sv
// ----------------------------------------------------------------------------
// chp_out_buf
// Two-entry result buffer so results keep flowing while the sink stalls.
// ----------------------------------------------------------------------------
module chp_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  chp_pkg::result_t    push_res,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output chp_pkg::result_t    out_res
);

	chp_pkg::result_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign room      = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_res   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_res;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/container_header_parser.sv
// ----------------------------------------------------------------------------
// container_header_parser
// Checks and unpacks the 16-byte container header of a byte stream.
//
//   channel   dir   fields
//   s_axis    in    tdata: byte_value[7:0]; tlast: last_byte
//   m_axis    out   tuser: status[1:0]; tdata: mode, flags, param,
//                   length word, checksum word (lowest bits first)
//   cfg       in    wr_data: max_mode[7:0], written when wr_en is high
//
// One byte per cycle is accepted back to back unless the input stalls (below).
// A result enters the result buffer once its final byte has been taken into
// the input register: the input register feeds the result buffer directly.
// The two-entry result buffer keeps the input flowing while the sink stalls;
// input stalls only when both entries are full and a final byte waits.
// Reset clears all header state and sets max_mode to four.
// ----------------------------------------------------------------------------
module container_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // mode, flags, param, length word, checksum word
	output logic [1:0]  m_axis_tuser    // status
);

	logic             res_room;
	logic             res_valid;
	chp_pkg::result_t res;
	chp_pkg::result_t out_res;

	// header tracking
	chp_hdr_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.res_room    (res_room),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result buffer
	chp_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.room      (res_room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// output packing
	assign m_axis_tuser = out_res.status;
	assign m_axis_tdata = {out_res.pay_crc, out_res.pay_len,
		out_res.param, out_res.flags, out_res.mode};

endmodule
